@@ rtl/fpba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fpba_pkg: shared types and constants of the fit policy block allocator
// Holds the operation and policy codes, the sequencer states, the register
// indexes and the request and result records passed between the modules.
// ----------------------------------------------------------------------------
package fpba_pkg;

	// Default sizing of the block table.
	localparam int MAX_BLOCKS_DEF = 16;
	localparam int SIZE_WIDTH_DEF = 16;

	// Fixed widths of the port fields.
	localparam int OP_W       = 2;
	localparam int IN_IDX_W   = 4;
	localparam int AMOUNT_W   = 16;
	localparam int NUM_W      = 5;
	localparam int CFG_DATA_W = 5;
	localparam int POLICY_W   = 2;

	// Block count after reset.
	localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RESET = 5'd16;

	// Operation codes carried by an input item. OP_NONE does nothing.
	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_NEW_RUN = 2'd1,
		OP_ALLOC   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// Placement policies.
	typedef enum logic [POLICY_W-1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2,
		FIT_NEXT  = 2'd3
	} fit_t;

	// Configuration register indexes.
	typedef enum logic {
		CFG_FIT_POLICY  = 1'b0,
		CFG_BLOCK_COUNT = 1'b1
	} cfg_reg_t;

	// Scan sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_RESULT = 2'd2
	} state_t;

	// Request handed from the input side to the scan sequencer.
	typedef struct packed {
		op_t                 op;
		logic [AMOUNT_W-1:0] amount;
	} alloc_req_t;

	// Outcome of one allocate request.
	typedef struct packed {
		logic             granted;
		logic [NUM_W-1:0] block_number;
	} alloc_result_t;

endpackage : fpba_pkg
`default_nettype wire

@@ rtl/fit_policy_block_allocator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core: fixed-partition block allocator
// Loads a table of block sizes, clears occupancy on a new run and grants at most one
// free block per allocate request under first, best, worst or next fit.
// ----------------------------------------------------------------------------
// A load, a new run or an unused op code gives no result. For an allocate
// request the sequencer fetches one block size per cycle through the single
// read port of the size table and compares it in the following cycle; first
// and next fit stop at the first fitting block, and a block count of zero
// skips the scan. The input side is not ready while a request is being
// scanned. The result waits in an output register, and the next item is
// taken while it waits. Configuration writes are taken in every cycle and
// must only be made while the block is idle. No clearing pass runs after
// reset.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_core
	import fpba_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input items
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [OP_W-1:0]       op,
	input  wire logic [IN_IDX_W-1:0]   block_index,
	input  wire logic [AMOUNT_W-1:0]   amount,
	// Results
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       granted,
	output logic      [NUM_W-1:0]      block_number,
	// Configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	fit_t                  policy_q;
	logic [CFG_DATA_W-1:0] block_count_q;
	logic                  out_valid_q;
	alloc_result_t         out_q;
	logic                  out_free;
	logic                  in_xfer;
	logic                  idle;
	logic                  wr_en;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic [SIZE_WIDTH-1:0] rd_data;
	logic                  res_valid;
	alloc_result_t         res;
	alloc_req_t            req;

	assign cfg_ready = 1'b1;
	assign in_ready  = idle;
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign req.op     = op_t'(op);
	assign req.amount = amount;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q      <= FIT_FIRST;
			block_count_q <= BLOCK_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FIT_POLICY:  policy_q      <= fit_t'(cfg_data[POLICY_W-1:0]);
				CFG_BLOCK_COUNT: block_count_q <= cfg_data;
			endcase
		end
	end

	// Loads beyond the table depth are dropped.
	assign wr_en = in_xfer && (op_t'(op) == OP_LOAD) && (32'(block_index) < MAX_BLOCKS);

	fpba_size_mem #(
		.DEPTH (MAX_BLOCKS),
		.WIDTH (SIZE_WIDTH)
	) u_size_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (IDX_W'(block_index)),
		.wr_data (SIZE_WIDTH'(amount)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fpba_scan #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_xfer),
		.req         (req),
		.fit_policy  (policy_q),
		.block_count (block_count_q),
		.idle        (idle),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.out_free    (out_free),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Output register: holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign granted      = out_q.granted;
	assign block_number = out_q.block_number;

endmodule : fit_policy_block_allocator_core
`default_nettype wire

@@ rtl/fpba_size_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fpba_size_mem: block size table
// Single write port and single read port with registered read data. Entries
// hold no defined value until they are loaded.
// ----------------------------------------------------------------------------
module fpba_size_mem
	import fpba_pkg::*;
#(
	parameter int DEPTH = MAX_BLOCKS_DEF,
	parameter int WIDTH = SIZE_WIDTH_DEF,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule : fpba_size_mem
`default_nettype wire

@@ rtl/fpba_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fpba_scan: scan sequencer and compare unit
// Walks the blocks in use one per cycle through the size table read port,
// compares each fetched size against the request and the best candidate so
// far, and keeps the occupied marks and the next-fit pointer.
// ----------------------------------------------------------------------------
module fpba_scan
	import fpba_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int SIZE_WIDTH = SIZE_WIDTH_DEF,
	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire alloc_req_t            req,
	input  wire fit_t                  fit_policy,
	input  wire logic [CFG_DATA_W-1:0] block_count,
	output logic                       idle,
	output logic                       rd_en,
	output logic      [IDX_W-1:0]      rd_addr,
	input  wire logic [SIZE_WIDTH-1:0] rd_data,
	input  wire logic                  out_free,
	output logic                       res_valid,
	output alloc_result_t              res
);

	state_t                state_q, state_d;
	logic [MAX_BLOCKS-1:0] used_q;
	logic [IDX_W-1:0]      nptr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      n_calc;
	logic [IDX_W-1:0]      pos_q;
	logic [IDX_W-1:0]      pos_next;
	logic [IDX_W-1:0]      start_pos;
	logic [SIZE_WIDTH-1:0] want_q;
	logic [SIZE_WIDTH-1:0] best_q;
	logic [IDX_W-1:0]      pick_q;
	logic                  found_q;
	logic                  s1_valid_s1;
	logic [IDX_W-1:0]      pos_s1;
	logic                  last_s1;
	logic                  fits;
	logic                  take;
	logic                  issue;
	logic                  begin_alloc;
	logic                  begin_clear;

	// Blocks in use, with counts above the table depth clamped to it.
	always_comb begin
		if (32'(block_count) > MAX_BLOCKS) begin
			n_calc = CNT_W'(MAX_BLOCKS);
		end else begin
			n_calc = CNT_W'(block_count);
		end
	end

	// Next fit starts at the pointer when it lies inside the blocks in use.
	assign start_pos = ((fit_policy == FIT_NEXT) && (CNT_W'(nptr_q) < n_calc))
		? nptr_q : '0;

	// Circular step of the scan address.
	assign pos_next = ((CNT_W'(pos_q) + CNT_W'(1)) == n_q) ? '0 : (pos_q + IDX_W'(1));

	// Compare unit: free and large enough.
	assign fits = !used_q[pos_s1] && (rd_data >= want_q);

	// Sequencer next state and controls.
	always_comb begin
		state_d     = state_q;
		idle        = 1'b0;
		issue       = 1'b0;
		take        = 1'b0;
		res_valid   = 1'b0;
		begin_alloc = 1'b0;
		begin_clear = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					case (req.op)
						OP_NEW_RUN: begin_clear = 1'b1;
						OP_ALLOC: begin
							begin_alloc = 1'b1;
							state_d = (n_calc == '0) ? ST_RESULT : ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				issue = (cnt_q != n_q);
				if (s1_valid_s1) begin
					case (fit_policy)
						FIT_BEST:  take = fits && (!found_q || (rd_data < best_q));
						FIT_WORST: take = fits && (rd_data > best_q);
						default:   take = fits;
					endcase
					if (last_s1 || (take && ((fit_policy == FIT_FIRST) ||
						(fit_policy == FIT_NEXT)))) begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign rd_en   = issue;
	assign rd_addr = pos_q;

	assign res.granted      = found_q;
	assign res.block_number = found_q ? NUM_W'(32'(pick_q) + 1) : '0;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			s1_valid_s1 <= 1'b0;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			used_q      <= '0;
			nptr_q      <= '0;
		end else begin
			state_q     <= state_d;
			s1_valid_s1 <= issue && (state_d == ST_SCAN);
			if (begin_alloc) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			// Occupied marks and next-fit pointer.
			if (begin_clear) begin
				used_q <= '0;
				nptr_q <= '0;
			end else if (res_valid && found_q) begin
				used_q[pick_q] <= 1'b1;
				if (fit_policy == FIT_NEXT) begin
					nptr_q <= pick_q;
				end
			end
		end
	end

	// Scan datapath.
	always_ff @(posedge clk) begin
		if (begin_alloc) begin
			want_q <= SIZE_WIDTH'(req.amount);
			n_q    <= n_calc;
			pos_q  <= start_pos;
			best_q <= '0;
		end
		if (issue) begin
			pos_q   <= pos_next;
			pos_s1  <= pos_q;
			last_s1 <= ((cnt_q + CNT_W'(1)) == n_q);
		end
		if (take) begin
			pick_q <= pos_s1;
			best_q <= rd_data;
		end
	end

	// A granted block is marked occupied right after the result leaves.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && found_q) |=> used_q[$past(pick_q)])
		else $error("granted block not marked occupied");

	// Next fit leaves the pointer on the granted block.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && found_q && (fit_policy == FIT_NEXT)) |=> (nptr_q == $past(pick_q)))
		else $error("next-fit pointer not moved to granted block");

	// The scan never fetches more blocks than are in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= n_q))
		else $error("scan ran past the blocks in use");

	// Fetched data is only compared while the scan runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 |-> (state_q == ST_SCAN))
		else $error("compare stage active outside the scan");

endmodule : fpba_scan
`default_nettype wire
